/* rtl/sppu_pkg.sv */
// Shared types and constants for the stack push/pop unit.
`default_nettype none

package sppu_pkg;

    localparam int MEM_BYTES_DEF = 4096;

    localparam int REG_COUNT = 15;
    localparam logic [3:0] RSP_IDX = 4'd4;
    localparam logic [3:0] PC_SEL = 4'hF;

    localparam logic [7:0] OP_PUSH = 8'hA0;
    localparam logic [7:0] OP_POP = 8'hB0;

    typedef enum logic [1:0] {
        CMD_EXEC = 2'd0,
        CMD_MEM = 2'd1,
        CMD_REG = 2'd2,
        CMD_NONE = 2'd3
    } cmd_code_t;

    typedef enum logic [1:0] {
        ST_OK = 2'd0,
        ST_BAD_OP = 2'd1,
        ST_BAD_ADDR = 2'd2,
        ST_BAD_REG = 2'd3
    } status_code_t;

    typedef struct packed {
        logic         accept;
        logic         rd_op;
        logic         rd_ra;
        logic         decode;
        logic         push_wr;
        logic         pop_rd;
        logic         capture;
        logic         commit;
        logic         set_status;
        status_code_t status_code;
    } dp_cmd_t;

    typedef struct packed {
        logic exec_req;
        logic fetch_ok;
        logic op_valid;
        logic op_push;
        logic ra_bad;
        logic span_ok;
        logic cnt_last;
        logic cnt_zero;
    } dp_stat_t;

endpackage

`default_nettype wire

/* rtl/stack_push_pop_unit.sv */
// Top level of the stack push/pop unit: controller plus datapath.
//
// A request is taken at a rising edge where start is high and busy is low.
// command selects execute at pc, write one memory byte (address, data[7:0]),
// or write a register or pc (reg_index, data; index 15 is pc).
// Each request yields one result: done is high for exactly one cycle with
// status, pc, stack_pointer and moved_value valid in that cycle.
// The receiver cannot stall; the result is presented once and dropped.
// After acceptance, a memory or register write or an unused command goes
// straight to done. An execute checks the fetch address, then reads the
// opcode and register bytes and decodes them; a fetch outside memory, a
// bad opcode, register F or a stack out of range ends it with its status.
// pushq writes eight bytes and popq reads eight bytes, then both commit.
// The single-port byte memory sets the pace: two fetch reads, then eight
// byte writes or reads at one byte per cycle. busy stays high through the
// done cycle, so one request is in flight at a time and the next is taken
// in the cycle after done at the earliest.
// Reset clears pc, all registers and the controller; memory contents are
// undefined until written.
`default_nettype none

module stack_push_pop_unit
    import sppu_pkg::*;
#(
    parameter int MEM_BYTES = MEM_BYTES_DEF
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire logic [1:0]  command,
    input  wire logic [11:0] address,
    input  wire logic [3:0]  reg_index,
    input  wire logic [63:0] data,
    output logic             done,
    output logic [1:0]       status,
    output logic [11:0]      pc,
    output logic [63:0]      stack_pointer,
    output logic [63:0]      moved_value
);

    dp_cmd_t  cmd;
    dp_stat_t stat;

    sppu_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .stat  (stat),
        .cmd   (cmd),
        .busy  (busy),
        .done  (done)
    );

    sppu_datapath #(
        .MEM_BYTES (MEM_BYTES)
    ) u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .command       (command),
        .address       (address),
        .reg_index     (reg_index),
        .data          (data),
        .stat          (stat),
        .status        (status),
        .pc            (pc),
        .stack_pointer (stack_pointer),
        .moved_value   (moved_value)
    );

endmodule

`default_nettype wire

/* rtl/sppu_ctrl.sv */
// Sequencing state machine for fetch, decode and the eight-byte stack transfer.
`default_nettype none

module sppu_ctrl
    import sppu_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     start,
    input  wire dp_stat_t stat,
    output dp_cmd_t       cmd,
    output logic          busy,
    output logic          done
);

    typedef enum logic [8:0] {
        S_IDLE     = 9'b000000001,
        S_FETCH0   = 9'b000000010,
        S_FETCH1   = 9'b000000100,
        S_DECODE   = 9'b000001000,
        S_PUSH     = 9'b000010000,
        S_POP      = 9'b000100000,
        S_POP_LAST = 9'b001000000,
        S_COMMIT   = 9'b010000000,
        S_DONE     = 9'b100000000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd = '0;
        cmd.status_code = ST_OK;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.accept = 1'b1;
                    state_next = stat.exec_req ? S_FETCH0 : S_DONE;
                end
            end
            S_FETCH0:
            begin
                if (!stat.fetch_ok)
                begin
                    cmd.set_status = 1'b1;
                    cmd.status_code = ST_BAD_ADDR;
                    state_next = S_DONE;
                end
                else
                begin
                    cmd.rd_op = 1'b1;
                    state_next = S_FETCH1;
                end
            end
            S_FETCH1:
            begin
                cmd.rd_ra = 1'b1;
                state_next = S_DECODE;
            end
            S_DECODE:
            begin
                if (!stat.op_valid)
                begin
                    cmd.set_status = 1'b1;
                    cmd.status_code = ST_BAD_OP;
                    state_next = S_DONE;
                end
                else if (stat.ra_bad)
                begin
                    cmd.set_status = 1'b1;
                    cmd.status_code = ST_BAD_REG;
                    state_next = S_DONE;
                end
                else if (!stat.span_ok)
                begin
                    cmd.set_status = 1'b1;
                    cmd.status_code = ST_BAD_ADDR;
                    state_next = S_DONE;
                end
                else
                begin
                    cmd.decode = 1'b1;
                    state_next = stat.op_push ? S_PUSH : S_POP;
                end
            end
            S_PUSH:
            begin
                cmd.push_wr = 1'b1;
                if (stat.cnt_last)
                begin
                    state_next = S_COMMIT;
                end
            end
            S_POP:
            begin
                cmd.pop_rd = 1'b1;
                cmd.capture = !stat.cnt_zero;
                if (stat.cnt_last)
                begin
                    state_next = S_POP_LAST;
                end
            end
            S_POP_LAST:
            begin
                cmd.capture = 1'b1;
                state_next = S_COMMIT;
            end
            S_COMMIT:
            begin
                cmd.commit = 1'b1;
                state_next = S_DONE;
            end
            S_DONE:
            begin
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign busy = (state_reg != S_IDLE);
    assign done = (state_reg == S_DONE);

    a_done_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !busy)
        else $error("result strobe not followed by idle");

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.accept |=> busy)
        else $error("accepted request did not raise busy");

    a_commit_done: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit |=> done)
        else $error("commit not followed by result strobe");

    a_single_write: assert property (@(posedge clk) disable iff (!rst_n)
        !(cmd.push_wr && (cmd.pop_rd || cmd.accept || cmd.rd_ra)))
        else $error("memory port driven by two commands");

endmodule

`default_nettype wire

/* rtl/sppu_datapath.sv */
// Byte memory, register file, program counter and transfer datapath.
`default_nettype none

module sppu_datapath
    import sppu_pkg::*;
#(
    parameter int MEM_BYTES = MEM_BYTES_DEF
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire dp_cmd_t     cmd,
    input  wire logic [1:0]  command,
    input  wire logic [11:0] address,
    input  wire logic [3:0]  reg_index,
    input  wire logic [63:0] data,
    output dp_stat_t         stat,
    output logic [1:0]       status,
    output logic [11:0]      pc,
    output logic [63:0]      stack_pointer,
    output logic [63:0]      moved_value
);

    localparam int AW = $clog2(MEM_BYTES);
    localparam int XW = (AW > 13) ? AW : 13;

    logic [7:0]    mem [MEM_BYTES];
    logic [7:0]    mem_rdata_reg;
    logic          mem_we;
    logic [AW-1:0] mem_addr;
    logic [7:0]    mem_wdata;

    logic [63:0] rf_reg [REG_COUNT];
    logic [63:0] rf_next [REG_COUNT];
    logic [11:0] pc_reg;
    logic [11:0] pc_next;
    logic [1:0]  status_reg;
    logic [1:0]  status_next;
    logic [63:0] moved_reg;
    logic [63:0] moved_next;

    logic [7:0]    op_reg;
    logic [3:0]    ra_reg;
    logic [AW-1:0] base_reg;
    logic [63:0]   shift_reg;
    logic [63:0]   sp_new_reg;
    logic [2:0]    cnt_reg;

    logic [XW-1:0] addr_x;
    logic [XW-1:0] pc_x;
    logic [XW-1:0] pc1_x;
    logic [3:0]    ra;
    logic [63:0]   rsp;
    logic [63:0]   push_top;
    logic [63:0]   span_lim;
    logic          addr_ok;
    logic          is_push;

    assign addr_x = XW'(address);
    assign pc_x = XW'(pc_reg);
    assign pc1_x = XW'(pc_reg) + XW'(1);
    assign ra = mem_rdata_reg[7:4];
    assign rsp = rf_reg[RSP_IDX];
    assign push_top = rsp - 64'd8;
    assign span_lim = 64'(MEM_BYTES) - 64'd8;
    assign addr_ok = 64'(address) < 64'(MEM_BYTES);
    assign is_push = (op_reg == OP_PUSH);

    assign stat.exec_req = (command == CMD_EXEC);
    assign stat.fetch_ok = (64'(pc_reg) + 64'd1) < 64'(MEM_BYTES);
    assign stat.op_valid = is_push || (op_reg == OP_POP);
    assign stat.op_push = is_push;
    assign stat.ra_bad = (ra == PC_SEL);
    assign stat.span_ok = is_push ? (push_top <= span_lim) : (rsp <= span_lim);
    assign stat.cnt_last = (cnt_reg == 3'd7);
    assign stat.cnt_zero = (cnt_reg == 3'd0);

    always_comb
    begin
        mem_we = 1'b0;
        mem_addr = pc_x[AW-1:0];
        mem_wdata = data[7:0];
        if (cmd.accept && (command == CMD_MEM) && addr_ok)
        begin
            mem_we = 1'b1;
            mem_addr = addr_x[AW-1:0];
        end
        else if (cmd.rd_op)
        begin
            mem_addr = pc_x[AW-1:0];
        end
        else if (cmd.rd_ra)
        begin
            mem_addr = pc1_x[AW-1:0];
        end
        else if (cmd.push_wr)
        begin
            mem_we = 1'b1;
            mem_addr = base_reg + AW'(cnt_reg);
            mem_wdata = shift_reg[7:0];
        end
        else if (cmd.pop_rd)
        begin
            mem_addr = base_reg + AW'(cnt_reg);
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_addr] <= mem_wdata;
        end
        mem_rdata_reg <= mem[mem_addr];
    end

    always_comb
    begin
        rf_next = rf_reg;
        pc_next = pc_reg;
        status_next = status_reg;
        moved_next = moved_reg;
        if (cmd.accept)
        begin
            moved_next = '0;
            status_next = ((command == CMD_MEM) && !addr_ok) ? ST_BAD_ADDR : ST_OK;
            if (command == CMD_REG)
            begin
                if (reg_index == PC_SEL)
                begin
                    pc_next = data[11:0];
                end
                else
                begin
                    rf_next[reg_index] = data;
                end
            end
        end
        if (cmd.set_status)
        begin
            status_next = cmd.status_code;
        end
        if (cmd.decode && is_push)
        begin
            moved_next = rf_reg[ra];
        end
        if (cmd.commit)
        begin
            rf_next[RSP_IDX] = sp_new_reg;
            pc_next = pc_reg + 12'd2;
            if (!is_push)
            begin
                rf_next[ra_reg] = shift_reg;
                moved_next = shift_reg;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < REG_COUNT; i++)
            begin
                rf_reg[i] <= '0;
            end
            pc_reg <= '0;
            status_reg <= ST_OK;
            moved_reg <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            rf_reg <= rf_next;
            pc_reg <= pc_next;
            status_reg <= status_next;
            moved_reg <= moved_next;
            if (cmd.decode)
            begin
                cnt_reg <= '0;
            end
            else if (cmd.push_wr || cmd.pop_rd)
            begin
                cnt_reg <= cnt_reg + 3'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.rd_ra)
        begin
            op_reg <= mem_rdata_reg;
        end
        if (cmd.decode)
        begin
            ra_reg <= ra;
            base_reg <= is_push ? push_top[AW-1:0] : rsp[AW-1:0];
            sp_new_reg <= is_push ? push_top : (rsp + 64'd8);
            shift_reg <= rf_reg[ra];
        end
        else if (cmd.push_wr)
        begin
            shift_reg <= {8'd0, shift_reg[63:8]};
        end
        else if (cmd.capture)
        begin
            shift_reg <= {mem_rdata_reg, shift_reg[63:8]};
        end
    end

    assign status = status_reg;
    assign pc = pc_reg;
    assign stack_pointer = rf_reg[RSP_IDX];
    assign moved_value = moved_reg;

endmodule

`default_nettype wire

/* tb/stack_push_pop_unit_tb.sv */
// Self-checking testbench for the stack push/pop unit: random and directed requests.
`timescale 1ns / 1ps

module stack_push_pop_unit_tb;
    import sppu_pkg::*;

    localparam int MEM_SIZE = MEM_BYTES_DEF;
    localparam int ITEM_TOTAL = 1650;
    localparam int IDLE_LIMIT = 2000;

    typedef struct {
        cmd_code_t   command;
        logic [11:0] address;
        logic [3:0]  reg_index;
        logic [63:0] data;
    } request_t;

    typedef struct {
        status_code_t status;
        logic [11:0]  pc;
        logic [63:0]  rsp;
        logic [63:0]  moved;
    } outcome_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        start = 1'b0;
    logic [1:0]  command = 2'd0;
    logic [11:0] address = 12'd0;
    logic [3:0]  reg_index = 4'd0;
    logic [63:0] data = 64'd0;
    logic        busy;
    logic        done;
    logic [1:0]  status;
    logic [11:0] pc;
    logic [63:0] stack_pointer;
    logic [63:0] moved_value;

    bit [7:0]  shadow_mem [MEM_SIZE];
    bit        mem_written [MEM_SIZE];
    bit [63:0] shadow_regs [REG_COUNT];
    bit [11:0] shadow_pc;

    request_t pending_requests[$];
    outcome_t expected_outcomes[$];
    request_t active_req;
    int issued_count = 0;
    int driven_count = 0;
    int accepted_count = 0;
    int gap_left = 0;
    int burst_left = 0;
    int idle_cycles = 0;
    int result_count = 0;
    int mismatch_count = 0;

    stack_push_pop_unit dut (
        .clk(clk),
        .rst_n(rst_n),
        .start(start),
        .busy(busy),
        .command(command),
        .address(address),
        .reg_index(reg_index),
        .data(data),
        .done(done),
        .status(status),
        .pc(pc),
        .stack_pointer(stack_pointer),
        .moved_value(moved_value)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    function automatic outcome_t apply_request(request_t r);
        outcome_t o;
        logic [7:0] op;
        logic [3:0] ra;
        logic [63:0] sp;
        logic [63:0] top;
        logic [63:0] val;
        int p;
        o.status = ST_OK;
        o.moved = '0;
        case (r.command)
            CMD_EXEC:
            begin
                p = shadow_pc;
                if (p + 1 >= MEM_SIZE)
                    o.status = ST_BAD_ADDR;
                else
                begin
                    op = shadow_mem[p];
                    ra = shadow_mem[p + 1][7:4];
                    sp = shadow_regs[RSP_IDX];
                    if (op != OP_PUSH && op != OP_POP)
                        o.status = ST_BAD_OP;
                    else if (ra == PC_SEL)
                        o.status = ST_BAD_REG;
                    else if (op == OP_PUSH)
                    begin
                        top = sp - 64'd8;
                        if (top > 64'(MEM_SIZE - 8))
                            o.status = ST_BAD_ADDR;
                        else
                        begin
                            val = shadow_regs[ra];
                            for (int i = 0; i < 8; i++)
                            begin
                                shadow_mem[int'(top) + i] = val[8*i +: 8];
                                mem_written[int'(top) + i] = 1'b1;
                            end
                            shadow_regs[RSP_IDX] = top;
                            o.moved = val;
                            shadow_pc = shadow_pc + 12'd2;
                        end
                    end
                    else if (sp > 64'(MEM_SIZE - 8))
                        o.status = ST_BAD_ADDR;
                    else
                    begin
                        for (int i = 0; i < 8; i++)
                            val[8*i +: 8] = shadow_mem[int'(sp) + i];
                        shadow_regs[RSP_IDX] = sp + 64'd8;
                        shadow_regs[ra] = val;
                        o.moved = val;
                        shadow_pc = shadow_pc + 12'd2;
                    end
                end
            end
            CMD_MEM:
            begin
                if (int'(r.address) < MEM_SIZE)
                begin
                    shadow_mem[r.address] = r.data[7:0];
                    mem_written[r.address] = 1'b1;
                end
                else
                    o.status = ST_BAD_ADDR;
            end
            CMD_REG:
            begin
                if (r.reg_index == PC_SEL)
                    shadow_pc = r.data[11:0];
                else
                    shadow_regs[r.reg_index] = r.data;
            end
            default: ;
        endcase
        o.pc = shadow_pc;
        o.rsp = shadow_regs[RSP_IDX];
        return o;
    endfunction

    function automatic logic [63:0] pick_stack_pointer();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 64'($urandom_range(8, MEM_SIZE));
        else if (r < 70)
            return 64'(MEM_SIZE);
        else if (r < 75)
            return 64'(MEM_SIZE - 8);
        else if (r < 80)
            return 64'(MEM_SIZE - 7);
        else if (r < 85)
            return 64'd8;
        else if (r < 90)
            return 64'($urandom_range(0, 7));
        return rand64();
    endfunction

    task automatic issue(cmd_code_t c, logic [11:0] a, logic [3:0] idx, logic [63:0] d);
        request_t r;
        r.command = c;
        r.address = a;
        r.reg_index = idx;
        r.data = d;
        pending_requests.push_back(r);
        issued_count++;
        wait (accepted_count == issued_count);
    endtask

    task automatic exec_at_pc();
        int hole;
        int p;
        logic [63:0] sp;
        do
        begin
            hole = -1;
            p = shadow_pc;
            sp = shadow_regs[RSP_IDX];
            if (p + 1 < MEM_SIZE)
            begin
                if (!mem_written[p])
                    hole = p;
                else if (!mem_written[p + 1])
                    hole = p + 1;
                else if (shadow_mem[p] == OP_POP && shadow_mem[p + 1][7:4] != PC_SEL
                         && sp <= 64'(MEM_SIZE - 8))
                begin
                    for (int i = 7; i >= 0; i--)
                        if (!mem_written[int'(sp) + i])
                            hole = int'(sp) + i;
                end
            end
            if (hole >= 0)
                issue(CMD_MEM, 12'(hole), 4'($urandom), rand64());
        end
        while (hole >= 0);
        issue(CMD_EXEC, 12'($urandom), 4'($urandom), rand64());
    endtask

    task automatic run_program();
        int steps;
        logic [11:0] at;
        logic [7:0] opc;
        logic [3:0] ra;
        int r;
        steps = $urandom_range(1, 6);
        if ($urandom_range(0, 3) == 0)
            issue(CMD_REG, 12'($urandom), PC_SEL, rand64());
        if ($urandom_range(0, 1) == 0)
            issue(CMD_REG, 12'($urandom), RSP_IDX, pick_stack_pointer());
        if ($urandom_range(0, 1) == 0)
            issue(CMD_REG, 12'($urandom), 4'($urandom_range(0, REG_COUNT - 1)), rand64());
        at = shadow_pc;
        for (int k = 0; k < steps; k++)
        begin
            r = $urandom_range(0, 9);
            opc = (r < 4) ? OP_PUSH : (r < 9) ? OP_POP : 8'($urandom);
            ra = ($urandom_range(0, 15) == 0) ? PC_SEL : 4'($urandom_range(0, REG_COUNT - 1));
            issue(CMD_MEM, at, 4'($urandom), {$urandom, 24'($urandom), opc});
            issue(CMD_MEM, at + 12'd1, 4'($urandom), {$urandom, 24'($urandom), ra, 4'($urandom)});
            at = at + 12'd2;
        end
        repeat (steps)
            exec_at_pc();
    endtask

    task automatic compare_field(string field, logic [63:0] want, logic [63:0] got);
        if (got !== want)
        begin
            mismatch_count++;
            if (mismatch_count <= 10)
                $display("result %0d: %s expected %h got %h", result_count, field, want, got);
        end
    endtask

    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (start && accepted_count == driven_count)
            begin
                if (burst_left > 0)
                begin
                    burst_left--;
                    gap_left = 0;
                end
                else
                begin
                    case ($urandom_range(0, 19))
                        0, 1, 2, 3, 4, 5, 6, 7, 8, 9: gap_left = 0;
                        10, 11, 12, 13, 14, 15, 16: gap_left = $urandom_range(1, 3);
                        17, 18: gap_left = $urandom_range(4, 12);
                        default: gap_left = $urandom_range(20, 60);
                    endcase
                    if ($urandom_range(0, 49) == 0)
                        burst_left = $urandom_range(10, 40);
                end
            end
            if (!start || accepted_count == driven_count)
            begin
                if (gap_left == 0 && pending_requests.size() > 0)
                begin
                    active_req = pending_requests.pop_front();
                    driven_count++;
                    start <= 1'b1;
                    command <= active_req.command;
                    address <= active_req.address;
                    reg_index <= active_req.reg_index;
                    data <= active_req.data;
                end
                else
                begin
                    start <= 1'b0;
                    if (gap_left > 0)
                        gap_left--;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        outcome_t want;
        if (rst_n)
        begin
            idle_cycles++;
            if (done)
            begin
                idle_cycles = 0;
                result_count++;
                if (expected_outcomes.size() == 0)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("result %0d: no request waiting for it", result_count);
                end
                else
                begin
                    want = expected_outcomes.pop_front();
                    compare_field("status", 64'(want.status), 64'(status));
                    compare_field("pc", 64'(want.pc), 64'(pc));
                    compare_field("stack_pointer", want.rsp, stack_pointer);
                    compare_field("moved_value", want.moved, moved_value);
                end
            end
            if (start && !busy)
            begin
                idle_cycles = 0;
                expected_outcomes.push_back(apply_request(active_req));
                accepted_count++;
            end
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("Mismatches found");
                $finish;
            end
        end
    end

    initial
    begin
        int r;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        issue(CMD_NONE, 12'hFFF, 4'hF, '1);
        issue(CMD_REG, 12'h000, 4'd0, '1);
        issue(CMD_REG, 12'h000, RSP_IDX, 64'(MEM_SIZE));
        issue(CMD_MEM, 12'h000, 4'd0, 64'(OP_PUSH));
        issue(CMD_MEM, 12'h001, 4'd0, 64'h0F);
        issue(CMD_EXEC, 12'h000, 4'd0, '0);
        issue(CMD_MEM, 12'h002, 4'd0, 64'(OP_POP));
        issue(CMD_MEM, 12'h003, 4'd0, 64'h4A);
        issue(CMD_EXEC, 12'hFFF, 4'hF, '1);
        issue(CMD_MEM, 12'h004, 4'd0, 64'(OP_POP));
        issue(CMD_MEM, 12'h005, 4'd0, 64'h3C);
        issue(CMD_EXEC, 12'h000, 4'd0, '0);
        issue(CMD_REG, 12'h000, RSP_IDX, 64'(MEM_SIZE - 7));
        issue(CMD_EXEC, 12'h000, 4'd0, '0);
        issue(CMD_MEM, 12'h004, 4'd0, 64'(OP_PUSH));
        issue(CMD_REG, 12'h000, RSP_IDX, 64'd0);
        issue(CMD_EXEC, 12'h000, 4'd0, '0);
        issue(CMD_MEM, 12'h004, 4'd0, 64'h0);
        issue(CMD_EXEC, 12'h000, 4'd0, '0);
        issue(CMD_MEM, 12'h004, 4'd0, 64'(OP_POP));
        issue(CMD_MEM, 12'h005, 4'd0, 64'hF0);
        issue(CMD_EXEC, 12'h000, 4'd0, '0);
        issue(CMD_REG, 12'h000, PC_SEL, '1);
        issue(CMD_EXEC, 12'h000, 4'd0, '0);
        issue(CMD_REG, 12'h000, PC_SEL, 64'h0123_4567_89AB_CFFE);
        issue(CMD_REG, 12'h000, RSP_IDX, 64'd8);
        issue(CMD_MEM, 12'hFFE, 4'd0, 64'(OP_PUSH));
        issue(CMD_MEM, 12'hFFF, 4'd0, 64'h45);
        issue(CMD_EXEC, 12'h000, 4'd0, '0);

        while (issued_count < ITEM_TOTAL)
        begin
            r = $urandom_range(0, 99);
            if (r < 45)
                run_program();
            else if (r < 60)
            begin
                issue(CMD_REG, 12'($urandom), 4'($urandom),
                      ($urandom_range(0, 1) == 0) ? pick_stack_pointer() : rand64());
            end
            else if (r < 75)
                issue(CMD_MEM, 12'($urandom), 4'($urandom), rand64());
            else if (r < 85)
                exec_at_pc();
            else if (r < 90)
                issue(CMD_NONE, 12'($urandom), 4'($urandom), rand64());
            else
                issue(CMD_REG, 12'($urandom), PC_SEL,
                      {52'(rand64() >> 12), 12'(MEM_SIZE - $urandom_range(1, 3))});
        end

        while (expected_outcomes.size() != 0)
            @(posedge clk);
        repeat (30) @(posedge clk);
        if (mismatch_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
